// ===== hw/rtl/mer_pkg.sv =====
// Shared types and constants for the midpoint ellipse rasterizer.
// No dependencies; mer_engine, the top level and the checker import this package.
`timescale 1ns / 1ps

package mer_pkg;

  // Command codes carried on the input channel.
  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  // Index of the fourth and final pixel of a run.
  localparam logic [1:0] PIX_LAST = 2'd3;

  // Which part of the ellipse the next advance works on.
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_R1,
    PH_R2
  } phase_t;

  // Sequencer states of the engine.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_S_RX,   // start: issue rx*rx
    ST_S_RY,   // start: issue ry*ry, take rx^2
    ST_S_T,    // start: issue rx^2*ry, take ry^2
    ST_S_D,    // start: form the region-1 decision value
    ST_STEP_A, // advance: move coordinates and slope terms
    ST_STEP_B, // advance: update the decision value
    ST_EMIT,   // hand four pixels to the output register
    ST_I_XX,   // region-2 setup: issue x*(x+1)
    ST_I_BX,   // region-2 setup: issue ry^2*x*(x+1)
    ST_I_YY,   // region-2 setup: issue (y-1)^2
    ST_I_AY,   // region-2 setup: issue rx^2*(y-1)^2
    ST_I_AB,   // region-2 setup: issue rx^2*ry^2
    ST_I_FIN   // region-2 setup: finish the decision value
  } eng_state_t;

  // Control of one pixel transfer from the engine to the output stage.
  typedef struct packed {
    logic valid;
    logic neg_x;
    logic neg_y;
    logic last;
    logic done;
  } pix_ctl_t;

endpackage

// ===== hw/rtl/mer_in_if.sv =====
// Input channel of the ellipse rasterizer: command and ellipse operands.
// Valid/ready handshake; no dependencies.
`timescale 1ns / 1ps

interface mer_in_if #(
  parameter int COORD_BITS  = 12,
  parameter int RADIUS_BITS = 10
);
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic signed [COORD_BITS-1:0]  center_x;
  logic signed [COORD_BITS-1:0]  center_y;
  logic        [RADIUS_BITS-1:0] radius_x;
  logic        [RADIUS_BITS-1:0] radius_y;

  modport source (output valid, cmd, center_x, center_y, radius_x, radius_y, input ready);
  modport sink   (input valid, cmd, center_x, center_y, radius_x, radius_y, output ready);
endinterface

// ===== hw/rtl/mer_out_if.sv =====
// Result channel of the ellipse rasterizer: one pixel per transfer.
// Valid/ready handshake; no dependencies.
`timescale 1ns / 1ps

interface mer_out_if #(
  parameter int COORD_BITS = 12
);
  logic                        valid;
  logic                        ready;
  logic signed [COORD_BITS:0]  pixel_x;
  logic signed [COORD_BITS:0]  pixel_y;
  logic                        last;
  logic                        done_res;

  modport source (output valid, pixel_x, pixel_y, last, done_res, input ready);
  modport sink   (input valid, pixel_x, pixel_y, last, done_res, output ready);
endinterface

// ===== hw/rtl/mer_mul.sv =====
// Shared unsigned multiplier with a registered product.
// Used by the engine for every square and product; no package needed.
`timescale 1ns / 1ps

module mer_mul #(
  parameter int W = 21
) (
  input  logic           clk,
  input  logic [W-1:0]   op_a,
  input  logic [W-1:0]   op_b,
  output logic [2*W-1:0] prod_r
);

  // One product per cycle, available the cycle after the operands.
  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

// ===== hw/rtl/mer_engine.sv =====
// Sequencer and state of the midpoint ellipse rasterizer.
// Depends on mer_pkg; drives the shared multiplier mer_mul and feeds the output stage.
`timescale 1ns / 1ps

module mer_engine
  import mer_pkg::*;
#(
  parameter int RADIUS_BITS = 10,
  parameter int COORD_BITS  = 12
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_cmd,
  input  logic signed [COORD_BITS-1:0]    in_cx,
  input  logic signed [COORD_BITS-1:0]    in_cy,
  input  logic        [RADIUS_BITS-1:0]   in_rx,
  input  logic        [RADIUS_BITS-1:0]   in_ry,
  // Pixel request to the output stage
  output pix_ctl_t                        pix_ctl,
  input  logic                            pix_ready,
  output logic        [RADIUS_BITS-1:0]   pix_x,
  output logic        [RADIUS_BITS-1:0]   pix_y,
  output logic signed [COORD_BITS-1:0]    pix_cx,
  output logic signed [COORD_BITS-1:0]    pix_cy,
  // Shared multiplier
  output logic        [2*RADIUS_BITS:0]   mul_a,
  output logic        [2*RADIUS_BITS:0]   mul_b,
  input  logic        [4*RADIUS_BITS+1:0] mul_p
);

  localparam int R   = RADIUS_BITS;
  localparam int SQW = 2 * R;       // squared radius
  localparam int TW  = 3 * R;       // rx^2 * ry
  localparam int SW  = 3 * R + 2;   // signed slope terms
  localparam int MW  = 2 * R + 1;   // multiplier operand
  localparam int PW  = 2 * MW;      // multiplier product
  localparam int DW  = 4 * R + 4;   // signed decision value

  eng_state_t state_r, state_nxt;
  phase_t     phase_r, phase_nxt;
  logic [1:0] idx_r, idx_nxt;

  logic        [R-1:0]          cur_x_r, cur_x_nxt;
  logic        [R-1:0]          cur_y_r, cur_y_nxt;
  logic        [R-1:0]          rx_r, rx_nxt;
  logic signed [SW-1:0]         spx_r, spx_nxt;
  logic signed [SW-1:0]         spy_r, spy_nxt;
  logic signed [DW-1:0]         dec_r, dec_nxt;
  logic        [SQW-1:0]        rx2_r, rx2_nxt;
  logic        [SQW-1:0]        ry2_r, ry2_nxt;
  logic signed [COORD_BITS-1:0] cx_r, cx_nxt;
  logic signed [COORD_BITS-1:0] cy_r, cy_nxt;

  logic                 accept;
  logic                 dec_neg;
  logic                 dec_pos;
  logic                 r1_end;
  logic                 goto_r2;
  logic                 fin;
  logic                 run_end;
  logic signed [SW-1:0] two_a;
  logic signed [SW-1:0] two_b;
  logic signed [DW-1:0] a_d;
  logic signed [DW-1:0] b_d;
  logic signed [DW-1:0] spx_d;
  logic signed [DW-1:0] spy_d;
  logic signed [DW-1:0] p_d;
  logic [TW-1:0]        t_w;

  assign accept  = in_valid && in_ready;
  assign dec_neg = dec_r[DW-1];
  assign dec_pos = !dec_r[DW-1] && (dec_r != '0);

  // Region 1 ends once the x slope has caught up with the y slope.
  assign r1_end  = (spx_r >= spy_r);
  assign goto_r2 = (phase_r == PH_R1) && r1_end && (cur_y_r != '0);
  assign fin     = ((phase_r == PH_R1) && r1_end && (cur_y_r == '0)) ||
                   ((phase_r == PH_R2) && (cur_y_r == '0));
  assign run_end = pix_ready && (idx_r == PIX_LAST);

  // Operands widened to the slope and decision widths.
  assign two_a = $signed({{(SW-SQW-1){1'b0}}, rx2_r, 1'b0});
  assign two_b = $signed({{(SW-SQW-1){1'b0}}, ry2_r, 1'b0});
  assign a_d   = $signed({{(DW-SQW){1'b0}}, rx2_r});
  assign b_d   = $signed({{(DW-SQW){1'b0}}, ry2_r});
  assign spx_d = {{(DW-SW){spx_r[SW-1]}}, spx_r};
  assign spy_d = {{(DW-SW){spy_r[SW-1]}}, spy_r};
  assign p_d   = $signed({{(DW-PW){1'b0}}, mul_p});
  assign t_w   = mul_p[TW-1:0];

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_cmd == CMD_START)) begin
          state_nxt = ST_S_RX;
        end else if (accept && (phase_r != PH_IDLE)) begin
          state_nxt = ST_STEP_A;
        end
      end
      ST_S_RX:   state_nxt = ST_S_RY;
      ST_S_RY:   state_nxt = ST_S_T;
      ST_S_T:    state_nxt = ST_S_D;
      ST_S_D:    state_nxt = ST_EMIT;
      ST_STEP_A: state_nxt = ST_STEP_B;
      ST_STEP_B: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (run_end) begin
          state_nxt = goto_r2 ? ST_I_XX : ST_IDLE;
        end
      end
      ST_I_XX:  state_nxt = ST_I_BX;
      ST_I_BX:  state_nxt = ST_I_YY;
      ST_I_YY:  state_nxt = ST_I_AY;
      ST_I_AY:  state_nxt = ST_I_AB;
      ST_I_AB:  state_nxt = ST_I_FIN;
      ST_I_FIN: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Handshake, pixel request and multiplier operands.
  always_comb begin
    in_ready      = (state_r == ST_IDLE);
    pix_ctl.valid = (state_r == ST_EMIT);
    pix_ctl.neg_x = idx_r[0];
    pix_ctl.neg_y = idx_r[1];
    pix_ctl.last  = (idx_r == PIX_LAST);
    pix_ctl.done  = (idx_r == PIX_LAST) && fin;
    mul_a         = '0;
    mul_b         = '0;
    unique case (state_r)
      ST_S_RX: begin
        mul_a = MW'(rx_r);
        mul_b = MW'(rx_r);
      end
      ST_S_RY: begin
        mul_a = MW'(cur_y_r);
        mul_b = MW'(cur_y_r);
      end
      ST_S_T: begin
        mul_a = MW'(rx2_r);
        mul_b = MW'(cur_y_r);
      end
      ST_I_XX: begin
        mul_a = MW'(cur_x_r);
        mul_b = MW'({1'b0, cur_x_r} + {{R{1'b0}}, 1'b1});
      end
      ST_I_BX: begin
        mul_a = MW'(ry2_r);
        mul_b = mul_p[MW-1:0];
      end
      ST_I_YY: begin
        mul_a = MW'(cur_y_r - {{(R-1){1'b0}}, 1'b1});
        mul_b = MW'(cur_y_r - {{(R-1){1'b0}}, 1'b1});
      end
      ST_I_AY: begin
        mul_a = MW'(rx2_r);
        mul_b = mul_p[MW-1:0];
      end
      ST_I_AB: begin
        mul_a = MW'(rx2_r);
        mul_b = MW'(ry2_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Datapath updates for each sequencer state.
  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    rx_nxt    = rx_r;
    spx_nxt   = spx_r;
    spy_nxt   = spy_r;
    dec_nxt   = dec_r;
    rx2_nxt   = rx2_r;
    ry2_nxt   = ry2_r;
    cx_nxt    = cx_r;
    cy_nxt    = cy_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_cmd == CMD_START)) begin
          cx_nxt    = in_cx;
          cy_nxt    = in_cy;
          rx_nxt    = in_rx;
          cur_x_nxt = '0;
          cur_y_nxt = in_ry;
          spx_nxt   = '0;
        end
      end
      ST_S_RY: rx2_nxt = mul_p[SQW-1:0];
      ST_S_T:  ry2_nxt = mul_p[SQW-1:0];
      ST_S_D: begin
        // Region-1 start value with the quarter term taken as rx^2 >> 2.
        spy_nxt   = $signed({{(SW-TW-1){1'b0}}, t_w, 1'b0});
        dec_nxt   = b_d - $signed({{(DW-TW){1'b0}}, t_w}) + (a_d >>> 2);
        phase_nxt = PH_R1;
        idx_nxt   = '0;
      end
      ST_STEP_A: begin
        if (phase_r == PH_R1) begin
          cur_x_nxt = cur_x_r + {{(R-1){1'b0}}, 1'b1};
          spx_nxt   = spx_r + two_b;
          if (!dec_neg) begin
            if (cur_y_r != '0) begin
              cur_y_nxt = cur_y_r - {{(R-1){1'b0}}, 1'b1};
            end
            spy_nxt = spy_r - two_a;
          end
        end else begin
          if (cur_y_r != '0) begin
            cur_y_nxt = cur_y_r - {{(R-1){1'b0}}, 1'b1};
          end
          spy_nxt = spy_r - two_a;
          if (!dec_pos) begin
            cur_x_nxt = cur_x_r + {{(R-1){1'b0}}, 1'b1};
            spx_nxt   = spx_r + two_b;
          end
        end
      end
      ST_STEP_B: begin
        // The slopes already hold their new values; the branch still follows dec_r.
        if (phase_r == PH_R1) begin
          dec_nxt = dec_neg ? (dec_r + b_d + spx_d) : (dec_r + b_d + spx_d - spy_d);
        end else begin
          dec_nxt = dec_pos ? (dec_r + a_d - spy_d) : (dec_r + a_d - spy_d + spx_d);
        end
        idx_nxt = '0;
      end
      ST_EMIT: begin
        if (pix_ready) begin
          idx_nxt = idx_r + 2'd1;
        end
        if (run_end && fin) begin
          phase_nxt = PH_IDLE;
        end
      end
      ST_I_YY:  dec_nxt = p_d + (b_d >>> 2);
      ST_I_AB:  dec_nxt = dec_r + p_d;
      ST_I_FIN: begin
        dec_nxt   = dec_r - p_d;
        phase_nxt = PH_R2;
      end
      default: begin
        dec_nxt = dec_r;
      end
    endcase
  end

  // Control state is reset; the arithmetic state is too, to match the idle state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PH_IDLE;
      idx_r   <= '0;
      cur_x_r <= '0;
      cur_y_r <= '0;
      rx_r    <= '0;
      spx_r   <= '0;
      spy_r   <= '0;
      dec_r   <= '0;
      rx2_r   <= '0;
      ry2_r   <= '0;
      cx_r    <= '0;
      cy_r    <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
      rx_r    <= rx_nxt;
      spx_r   <= spx_nxt;
      spy_r   <= spy_nxt;
      dec_r   <= dec_nxt;
      rx2_r   <= rx2_nxt;
      ry2_r   <= ry2_nxt;
      cx_r    <= cx_nxt;
      cy_r    <= cy_nxt;
    end
  end

  assign pix_x  = cur_x_r;
  assign pix_y  = cur_y_r;
  assign pix_cx = cx_r;
  assign pix_cy = cy_r;

endmodule

// ===== hw/rtl/midpoint_ellipse_raster_core.sv =====
// Top level of the midpoint ellipse rasterizer: engine, shared multiplier, output register.
// Depends on mer_pkg, mer_in_if, mer_out_if, mer_mul and mer_engine.
//
//   Channel | Direction | Payload                                  | Transfer
//   in_if   | sink      | cmd, center_x, center_y, radius_x/_y     | valid && ready
//   out_if  | source    | pixel_x, pixel_y, last, done_res         | valid && ready
//
// A start forms rx^2, ry^2 and rx^2*ry on the multiplier, then the decision value and its
// four pixels; an advance steps the point and slopes, then the decision value and four pixels.
// The step that closes region 1 then sets up region 2 through the shared multiplier.
// An advance while nothing is being drawn is accepted and gives no pixel.
// Reset is synchronous and active low; a stall on out_if holds the engine on its pixel.
`timescale 1ns / 1ps

module midpoint_ellipse_raster_core
  import mer_pkg::*;
#(
  parameter int RADIUS_BITS = 10,
  parameter int COORD_BITS  = 12
) (
  input  logic      clk,
  input  logic      rst_n,
  mer_in_if.sink    in_if,
  mer_out_if.source out_if
);

  localparam int MW = 2 * RADIUS_BITS + 1;
  localparam int AW = ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS) + 2;

  pix_ctl_t                        pix_ctl;
  logic                            pix_ready;
  logic        [RADIUS_BITS-1:0]   pix_x;
  logic        [RADIUS_BITS-1:0]   pix_y;
  logic signed [COORD_BITS-1:0]    pix_cx;
  logic signed [COORD_BITS-1:0]    pix_cy;
  logic        [MW-1:0]            mul_a;
  logic        [MW-1:0]            mul_b;
  logic        [2*MW-1:0]          mul_p;

  logic                            out_valid_r, out_valid_nxt;
  logic signed [COORD_BITS:0]      px_r, px_nxt;
  logic signed [COORD_BITS:0]      py_r, py_nxt;
  logic                            last_r, last_nxt;
  logic                            done_r, done_nxt;
  logic                            load;
  logic signed [AW-1:0]            cx_w, cy_w, x_w, y_w, sx_w, sy_w;

  mer_engine #(
    .RADIUS_BITS (RADIUS_BITS),
    .COORD_BITS  (COORD_BITS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .in_cmd    (in_if.cmd),
    .in_cx     (in_if.center_x),
    .in_cy     (in_if.center_y),
    .in_rx     (in_if.radius_x),
    .in_ry     (in_if.radius_y),
    .pix_ctl   (pix_ctl),
    .pix_ready (pix_ready),
    .pix_x     (pix_x),
    .pix_y     (pix_y),
    .pix_cx    (pix_cx),
    .pix_cy    (pix_cy),
    .mul_a     (mul_a),
    .mul_b     (mul_b),
    .mul_p     (mul_p)
  );

  mer_mul #(
    .W (MW)
  ) u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (mul_p)
  );

  // Mirror the current point about the center; coordinates wrap to the output width.
  assign cx_w = {{(AW-COORD_BITS){pix_cx[COORD_BITS-1]}}, pix_cx};
  assign cy_w = {{(AW-COORD_BITS){pix_cy[COORD_BITS-1]}}, pix_cy};
  assign x_w  = $signed({{(AW-RADIUS_BITS){1'b0}}, pix_x});
  assign y_w  = $signed({{(AW-RADIUS_BITS){1'b0}}, pix_y});
  assign sx_w = pix_ctl.neg_x ? (cx_w - x_w) : (cx_w + x_w);
  assign sy_w = pix_ctl.neg_y ? (cy_w - y_w) : (cy_w + y_w);

  // The output register takes a new pixel whenever it is empty or being drained.
  assign pix_ready = !out_valid_r || out_if.ready;
  assign load      = pix_ctl.valid && pix_ready;

  always_comb begin
    px_nxt        = px_r;
    py_nxt        = py_r;
    last_nxt      = last_r;
    done_nxt      = done_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    if (load) begin
      px_nxt        = sx_w[COORD_BITS:0];
      py_nxt        = sy_w[COORD_BITS:0];
      last_nxt      = pix_ctl.last;
      done_nxt      = pix_ctl.done;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    px_r   <= px_nxt;
    py_r   <= py_nxt;
    last_r <= last_nxt;
    done_r <= done_nxt;
  end

  assign out_if.valid    = out_valid_r;
  assign out_if.pixel_x  = px_r;
  assign out_if.pixel_y  = py_r;
  assign out_if.last     = last_r;
  assign out_if.done_res = done_r;

endmodule

// ===== hw/rtl/mer_checker.sv =====
// Port-level checks for the midpoint ellipse rasterizer, bound to the top level.
// Depends on mer_pkg and midpoint_ellipse_raster_core.
`timescale 1ns / 1ps

module mer_checker
  import mer_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       in_cmd,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [COORD_BITS:0] out_pixel_x,
  input logic signed [COORD_BITS:0] out_pixel_y,
  input logic                       out_last,
  input logic                       out_done_res
);

  // Reset empties the output register.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // A start keeps the input closed while the squares are formed.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_cmd == CMD_START) |=> !in_ready ##1 !in_ready ##1 !in_ready)
    else $error("input reopened during start setup");

  // The final pixel of an ellipse always closes its run.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> out_last)
    else $error("done_res without last");

  // A stalled pixel holds its payload.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_x) && $stable(out_pixel_y)
      && $stable(out_last) && $stable(out_done_res))
    else $error("stalled pixel changed");

endmodule

bind midpoint_ellipse_raster_core mer_checker #(
  .COORD_BITS (COORD_BITS)
) u_mer_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_if.valid),
  .in_ready     (in_if.ready),
  .in_cmd       (in_if.cmd),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .out_pixel_x  (out_if.pixel_x),
  .out_pixel_y  (out_if.pixel_y),
  .out_last     (out_if.last),
  .out_done_res (out_if.done_res)
);
